### src/assert_macros.svh
// Assertion macros shared by the checker files.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is high
`define TEA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion, also checked during reset
`define TEA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/tea_pkg.sv
// Shared types and constants for the TEA encryption pipeline.
// Depends on nothing; imported by tea_key_regs, tea_half_round and tea_block_encrypt.
package tea_pkg;

   localparam int ROUND_COUNT = 32;
   localparam int STAGE_COUNT = 2 * ROUND_COUNT;
   localparam int WORD_W      = 32;

   localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E37_79B9;

   typedef logic [WORD_W-1:0] word_type;

   typedef enum logic [1:0] {
      CSR_KEY_WORD0 = 2'd0,
      CSR_KEY_WORD1 = 2'd1,
      CSR_KEY_WORD2 = 2'd2,
      CSR_KEY_WORD3 = 2'd3
   } csr_index_type;

   typedef struct packed {
      word_type word0;
      word_type word1;
      word_type word2;
      word_type word3;
   } key_set_type;

   typedef struct packed {
      logic valid;
      logic advance;
   } stage_ctrl_type;

   // running sum after round number rnd (from 0), modulo 2^32
   function automatic word_type round_sum(input int rnd);
      logic [2*WORD_W-1:0] product;
      product = (2*WORD_W)'(TEA_DELTA) * (2*WORD_W)'(rnd + 1);
      return product[WORD_W-1:0];
   endfunction

endpackage

### src/tea_key_regs.sv
// Key word registers written through the csr channel.
// Depends on tea_pkg.
module tea_key_regs (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  tea_pkg::csr_index_type csr_index,
   input  tea_pkg::word_type     csr_data,
   output tea_pkg::key_set_type  key
);
   import tea_pkg::*;

   key_set_type key_ff;
   key_set_type key_in;

   assign csr_ready = 1'b1;
   assign key       = key_ff;

   always_comb begin
      key_in = key_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_KEY_WORD0: key_in.word0 = csr_data;
            CSR_KEY_WORD1: key_in.word1 = csr_data;
            CSR_KEY_WORD2: key_in.word2 = csr_data;
            CSR_KEY_WORD3: key_in.word3 = csr_data;
            default:       key_in = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

endmodule

### src/tea_half_round.sv
// One registered half round: upd += mix(src, sum, ka, kb), src passes.
// Depends on tea_pkg.
module tea_half_round (
   input  logic                   clock,
   input  logic                   reset,
   input  tea_pkg::stage_ctrl_type ctrl,
   input  tea_pkg::word_type      upd_word,
   input  tea_pkg::word_type      src_word,
   input  tea_pkg::word_type      sum,
   input  tea_pkg::word_type      key_a,
   input  tea_pkg::word_type      key_b,
   output logic                   valid,
   output tea_pkg::word_type      upd_out,
   output tea_pkg::word_type      src_out
);
   import tea_pkg::*;

   logic     valid_ff;
   word_type upd_ff;
   word_type src_ff;
   word_type upd_in;
   word_type mix_p;
   word_type mix_q;
   word_type mix_r;

   always_comb begin
      mix_p  = (src_word << 4) + key_a;
      mix_q  = src_word + sum;
      mix_r  = (src_word >> 5) + key_b;
      upd_in = upd_word + (mix_p ^ mix_q ^ mix_r);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.advance) begin
         valid_ff <= ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         upd_ff <= upd_in;
         src_ff <= src_word;
      end
   end

   assign valid   = valid_ff;
   assign upd_out = upd_ff;
   assign src_out = src_ff;

endmodule

### src/tea_block_encrypt.sv
// TEA block encryption, one half round per pipeline stage.
// Depends on tea_pkg, tea_key_regs and tea_half_round.
//
// Usage:
//   req channel: req_valid with req_block_left / req_block_right (plaintext).
//     A transfer happens on a clock edge with req_valid high, req_stall low.
//   rsp channel: rsp_valid with rsp_cipher_left / rsp_cipher_right.
//     A transfer happens on a clock edge with rsp_valid high, rsp_stall low.
//   csr channel: csr_valid / csr_ready with csr_index and csr_data write the
//     four key words; csr_ready is always high. Write keys only while idle.
// Pipeline: one register per half round; the last stage register drives the
//   rsp channel.
// Throughput: one block per cycle unless stalled; each stage takes one.
// Reset: synchronous, clears all stage valid bits and the key words.
// Stall: while the last stage holds a result and rsp_stall is high, every
//   stage holds, empty ones too, and req_stall is high in the same cycles.
module tea_block_encrypt (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tea_pkg::word_type      req_block_left,
   input  tea_pkg::word_type      req_block_right,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tea_pkg::word_type      rsp_cipher_left,
   output tea_pkg::word_type      rsp_cipher_right,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  tea_pkg::csr_index_type csr_index,
   input  tea_pkg::word_type      csr_data
);
   import tea_pkg::*;

   key_set_type key;

   logic     stage_valid [STAGE_COUNT+1];
   logic     stage_adv   [STAGE_COUNT+1];
   word_type stage_y     [STAGE_COUNT+1];
   word_type stage_z     [STAGE_COUNT+1];

   tea_key_regs u_key_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .key       (key)
   );

   assign stage_valid[0] = req_valid;
   assign stage_y[0]     = req_block_left;
   assign stage_z[0]     = req_block_right;

   // advance every stage unless the last one holds a stalled result
   assign stage_adv[STAGE_COUNT] = !stage_valid[STAGE_COUNT] || !rsp_stall;

   for (genvar k = 0; k < STAGE_COUNT; k++) begin : g_stage
      localparam word_type SUM = round_sum(k / 2);
      stage_ctrl_type ctrl;

      assign stage_adv[k] = stage_adv[k+1];
      assign ctrl.valid   = stage_valid[k];
      assign ctrl.advance = stage_adv[k];

      if (k % 2 == 0) begin : g_left
         tea_half_round u_half (
            .clock    (clock),
            .reset    (reset),
            .ctrl     (ctrl),
            .upd_word (stage_y[k]),
            .src_word (stage_z[k]),
            .sum      (SUM),
            .key_a    (key.word0),
            .key_b    (key.word1),
            .valid    (stage_valid[k+1]),
            .upd_out  (stage_y[k+1]),
            .src_out  (stage_z[k+1])
         );
      end else begin : g_right
         tea_half_round u_half (
            .clock    (clock),
            .reset    (reset),
            .ctrl     (ctrl),
            .upd_word (stage_z[k]),
            .src_word (stage_y[k]),
            .sum      (SUM),
            .key_a    (key.word2),
            .key_b    (key.word3),
            .valid    (stage_valid[k+1]),
            .upd_out  (stage_z[k+1]),
            .src_out  (stage_y[k+1])
         );
      end
   end

   assign req_stall        = !stage_adv[0];
   assign rsp_valid        = stage_valid[STAGE_COUNT];
   assign rsp_cipher_left  = stage_y[STAGE_COUNT];
   assign rsp_cipher_right = stage_z[STAGE_COUNT];

endmodule

### src/tea_checker.sv
// Port-level checks for tea_block_encrypt, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module tea_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_cipher_left,
   input logic [31:0] rsp_cipher_right
);

   logic        rsp_held;
   logic [63:0] rsp_pair;

   assign rsp_held = rsp_valid && rsp_stall;
   assign rsp_pair = {rsp_cipher_left, rsp_cipher_right};

   `TEA_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid, "rsp_valid after reset")

   `TEA_ASSERT(a_empty_no_stall, clock, reset, !rsp_valid |-> !req_stall, "stall while empty")

   `TEA_ASSERT(a_stalled_hold, clock, reset, rsp_held |=> rsp_valid, "result dropped")

   `TEA_ASSERT(a_hold_stable, clock, reset, rsp_held |=> $stable(rsp_pair), "held data changed")

endmodule

bind tea_block_encrypt tea_checker u_tea_checker (.*);

### tb/tea_cipher_checker.sv
// Checker for tea_block_encrypt: watches the req, rsp and csr channels and
// predicts each ciphertext pair in the order of accepted transfers.
// Depends on tea_pkg for the word, key and csr index types.
`timescale 1ns / 1ps

module tea_cipher_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  tea_pkg::word_type      req_block_left,
   input  tea_pkg::word_type      req_block_right,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  tea_pkg::word_type      rsp_cipher_left,
   input  tea_pkg::word_type      rsp_cipher_right,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  tea_pkg::csr_index_type csr_index,
   input  tea_pkg::word_type      csr_data,
   output int                     mismatch_count,
   output int                     cipher_pending,
   output int                     blocks_seen,
   output int                     ciphers_seen
);
   import tea_pkg::*;

   typedef struct packed {
      word_type left;
      word_type right;
   } cipher_pair_type;

   key_set_type     key_shadow;
   cipher_pair_type expected_cipher_q[$];

   function automatic cipher_pair_type encipher_block(word_type left, word_type right,
                                                      key_set_type key);
      word_type        y;
      word_type        z;
      word_type        acc;
      cipher_pair_type res;
      y   = left;
      z   = right;
      acc = '0;
      for (int n = 0; n < ROUND_COUNT; n++) begin
         acc = acc + TEA_DELTA;
         y = y + (((z << 4) + key.word0) ^ (z + acc) ^ ((z >> 5) + key.word1));
         z = z + (((y << 4) + key.word2) ^ (y + acc) ^ ((y >> 5) + key.word3));
      end
      res.left  = y;
      res.right = z;
      return res;
   endfunction

   task automatic report_failure(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : sample
      cipher_pair_type want;
      if (reset) begin
         key_shadow = '0;
         expected_cipher_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            ciphers_seen++;
            if (expected_cipher_q.size() == 0) begin
               report_failure($sformatf("cipher %h_%h with no block outstanding",
                                        rsp_cipher_left, rsp_cipher_right));
            end else begin
               want = expected_cipher_q.pop_front();
               if (rsp_cipher_left !== want.left)
                  report_failure($sformatf("cipher_left got %h want %h",
                                           rsp_cipher_left, want.left));
               if (rsp_cipher_right !== want.right)
                  report_failure($sformatf("cipher_right got %h want %h",
                                           rsp_cipher_right, want.right));
            end
         end
         if (req_valid && !req_stall) begin
            blocks_seen++;
            expected_cipher_q.push_back(encipher_block(req_block_left, req_block_right,
                                                       key_shadow));
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_KEY_WORD0: key_shadow.word0 = csr_data;
               CSR_KEY_WORD1: key_shadow.word1 = csr_data;
               CSR_KEY_WORD2: key_shadow.word2 = csr_data;
               CSR_KEY_WORD3: key_shadow.word3 = csr_data;
               default: ;
            endcase
         end
      end
      cipher_pending = expected_cipher_q.size();
   end

endmodule

### tb/tb_tea_block_encrypt.sv
// Testbench top for tea_block_encrypt: drives plaintext blocks and key words
// with random idling, instantiates tea_cipher_checker and gives the verdict.
// Depends on tea_pkg, tea_block_encrypt and tea_cipher_checker.
`timescale 1ns / 1ps

module tb_tea_block_encrypt;
   import tea_pkg::*;

   localparam int IDLE_LIMIT   = 4000;
   localparam int PHASE_COUNT  = 8;
   localparam int PHASE_BLOCKS = 143;

   logic          clock           = 1'b0;
   logic          reset           = 1'b1;
   logic          req_valid       = 1'b0;
   logic          req_stall;
   word_type      req_block_left  = '0;
   word_type      req_block_right = '0;
   logic          rsp_valid;
   logic          rsp_stall       = 1'b0;
   word_type      rsp_cipher_left;
   word_type      rsp_cipher_right;
   logic          csr_valid       = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index       = CSR_KEY_WORD0;
   word_type      csr_data        = '0;

   bit steady       = 1'b0;
   int idle_cycles  = 0;
   int key_settings = 0;
   int mismatch_count;
   int cipher_pending;
   int blocks_seen;
   int ciphers_seen;

   word_type corner_left  [9] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
                                  32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                                  32'hAAAA_AAAA, 32'h5555_5555, 32'h0123_4567};
   word_type corner_right [9] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  32'h0000_0000, 32'h0000_0001, 32'h8000_0000,
                                  32'h5555_5555, 32'hAAAA_AAAA, 32'h89AB_CDEF};

   tea_block_encrypt dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_block_left   (req_block_left),
      .req_block_right  (req_block_right),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_cipher_left  (rsp_cipher_left),
      .rsp_cipher_right (rsp_cipher_right),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   tea_cipher_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_block_left   (req_block_left),
      .req_block_right  (req_block_right),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_cipher_left  (rsp_cipher_left),
      .rsp_cipher_right (rsp_cipher_right),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .mismatch_count   (mismatch_count),
      .cipher_pending   (cipher_pending),
      .blocks_seen      (blocks_seen),
      .ciphers_seen     (ciphers_seen)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < 34);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("tea_block_encrypt verification failed");
            $finish;
         end
      end
   end

   function automatic word_type rand_word();
      int pick;
      pick = $urandom_range(0, 15);
      case (pick)
         0: return '0;
         1: return '1;
         2: return word_type'(1) << $urandom_range(0, WORD_W - 1);
         3: return ~(word_type'(1) << $urandom_range(0, WORD_W - 1));
         default: return word_type'($urandom);
      endcase
   endfunction

   // call at a falling edge; returns at the falling edge after the transfer
   task automatic send_block(word_type left, word_type right);
      while (!steady && ($urandom_range(0, 99) < 34)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_block_left  <= left;
      req_block_right <= right;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic load_key(key_set_type key);
      csr_index_type idx;
      for (int i = 0; i < 4; i++) begin
         idx = csr_index_type'(i);
         csr_valid <= 1'b1;
         csr_index <= idx;
         case (idx)
            CSR_KEY_WORD0: csr_data <= key.word0;
            CSR_KEY_WORD1: csr_data <= key.word1;
            CSR_KEY_WORD2: csr_data <= key.word2;
            CSR_KEY_WORD3: csr_data <= key.word3;
            default: ;
         endcase
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
      key_settings++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (cipher_pending != 0) @(negedge clock);
   endtask

   initial begin
      key_set_type key;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // corners under the reset key, then under the all-ones key
      key_settings = 1;
      foreach (corner_left[i]) send_block(corner_left[i], corner_right[i]);
      drain();
      load_key('1);
      foreach (corner_left[i]) send_block(corner_left[i], corner_right[i]);
      drain();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: key = '0;
            1: key = '1;
            2: key = '{word0: '1, word1: '0, word2: '1, word3: '0};
            3: key = '{word0: '0, word1: '1, word2: 32'h8000_0000, word3: 32'h0000_0001};
            default: key = '{word0: rand_word(), word1: rand_word(),
                             word2: rand_word(), word3: rand_word()};
         endcase
         load_key(key);
         for (int n = 0; n < PHASE_BLOCKS; n++) begin
            steady <= (phase == 4) || (n >= 60 && n < 80);
            send_block(rand_word(), rand_word());
         end
         steady <= 1'b0;
         drain();
      end

      repeat (STAGE_COUNT + 8) @(negedge clock);
      $display("Summary: %0d plaintext blocks encrypted under %0d key settings,",
               blocks_seen, key_settings);
      $display("         %0d ciphertext pairs compared, %0d mismatches.",
               ciphers_seen, mismatch_count);
      if (mismatch_count == 0 && cipher_pending == 0) begin
         $display("tea_block_encrypt verification clean");
      end else begin
         $display("tea_block_encrypt verification failed");
      end
      $finish;
   end

endmodule
